[rtl/krt_pkg.sv]
// shared types and codes for the keyed record table
// depends on nothing; used by krt_cell and keyed_record_table_top
package krt_pkg;

	localparam int KEY_W = 32;
	localparam int PAY_W = 32;

	// operation carried by the search token
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FULL   = 2'd2
	} tok_op_t;

	// result codes on the status port
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	// token that walks the cell row, one cell per cycle
	typedef struct packed {
		logic             active;
		tok_op_t          op;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic             hit;
		logic             placed;
	} tok_t;

endpackage

[rtl/krt_cell.sv]
// one slot of the record table: holds a key and payload, compares the passing token
// depends on krt_pkg
module krt_cell #(
	parameter int CNT_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  krt_pkg::tok_t             tok_i,
	input  logic [CNT_W-1:0]          rem_i,
	input  logic [krt_pkg::KEY_W-1:0] nxt_key_i,
	input  logic [krt_pkg::PAY_W-1:0] nxt_payload_i,
	output krt_pkg::tok_t             tok_o,
	output logic [CNT_W-1:0]          rem_o,
	output logic [krt_pkg::KEY_W-1:0] key_o,
	output logic [krt_pkg::PAY_W-1:0] payload_o
);
	import krt_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;
	tok_t             tok_q;
	logic [CNT_W-1:0] rem_q;
	tok_t             tok_nxt;
	logic             live;
	logic             match;
	logic             shift;
	logic             place;

	// slot holds a record while records remain ahead of the token
	assign live  = (rem_i != '0);
	assign match = tok_i.active && live && (key_q == tok_i.key);
	// after a remove hit every later slot pulls its neighbor down by one
	assign shift = tok_i.active && (tok_i.op == OP_REMOVE) && (tok_i.hit || match);
	// first empty slot takes a new record when no copy was seen
	assign place = tok_i.active && (tok_i.op == OP_INSERT) && !live
		&& !tok_i.hit && !tok_i.placed;

	always_comb begin
		tok_nxt        = tok_i;
		tok_nxt.hit    = tok_i.hit || match;
		tok_nxt.placed = tok_i.placed || place;
	end

	// record storage, no reset needed
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q     <= nxt_key_i;
			payload_q <= nxt_payload_i;
		end else if (place) begin
			key_q     <= tok_i.key;
			payload_q <= tok_i.payload;
		end
	end

	// token hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			rem_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			rem_q <= live ? (rem_i - CNT_W'(1)) : '0;
		end
	end

	assign tok_o     = tok_q;
	assign rem_o     = rem_q;
	assign key_o     = key_q;
	assign payload_o = payload_q;

endmodule

[rtl/keyed_record_table_top.sv]
// top level of the keyed record table: launch control, cell row, result register
// depends on krt_pkg and krt_cell
//
// Usage: one word on the input channel (action, key_value, payload_value) gives
// exactly one word on the output channel (status, entry_count). Both channels use
// valid/stall; a word moves when valid is high and stall is low.
// Records live in a row of CAPACITY cells. An accepted word launches a token that
// walks the row one cell per cycle: it compares against each stored key, places an
// inserted record in the first empty cell, and on a remove hit every later cell
// pulls its neighbor's record down, so the table stays packed.
// A result passes the launch register, the CAPACITY cells of the row, the pending
// register and the output register. One word is in flight at a time, so the input
// takes no new word until the last result has moved into the output register.
// The input stalls while a token is in the row or a result waits to be handed over.
// If the receiver stalls, the result is held and the finished word after it waits
// in a pending register; nothing is dropped.
// Reset clears the record count, the token and the output valid; stored records
// need no clearing since only slots below the count are ever looked at.
module keyed_record_table_top #(
	parameter int CAPACITY = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] key_value,
	input  logic signed [31:0] payload_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [7:0]         entry_count
);
	import krt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	tok_t             launch_q;
	logic [CNT_W-1:0] launch_rem_q;
	status_t          pend_status_q;
	logic [7:0]       pend_count_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [7:0]       out_count_q;

	tok_t             tok_w [0:CAPACITY];
	logic [CNT_W-1:0] rem_w [0:CAPACITY];
	logic [KEY_W-1:0] key_w [0:CAPACITY];
	logic [PAY_W-1:0] pay_w [0:CAPACITY];
	logic [CAPACITY:0] act_vec;

	logic             in_acc;
	logic             out_free;
	logic             tok_done;
	tok_t             tok_end;
	status_t          end_status;
	logic [CNT_W-1:0] end_count;
	tok_op_t          new_op;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// operation chosen at launch, fullness is settled before any search
	always_comb begin
		if (action) begin
			new_op = OP_REMOVE;
		end else if (count_q == CNT_W'(CAPACITY)) begin
			new_op = OP_FULL;
		end else begin
			new_op = OP_INSERT;
		end
	end

	// launch register feeding the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q     <= '0;
			launch_rem_q <= '0;
		end else begin
			launch_q.active <= in_acc;
			if (in_acc) begin
				launch_q.op      <= new_op;
				launch_q.key     <= key_value;
				launch_q.payload <= payload_value;
				launch_q.hit     <= 1'b0;
				launch_q.placed  <= 1'b0;
				launch_rem_q     <= count_q;
			end
		end
	end

	assign tok_w[0]        = launch_q;
	assign rem_w[0]        = launch_rem_q;
	assign key_w[CAPACITY] = '0;
	assign pay_w[CAPACITY] = '0;

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		krt_cell #(
			.CNT_W(CNT_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.tok_i        (tok_w[i]),
			.rem_i        (rem_w[i]),
			.nxt_key_i    (key_w[i+1]),
			.nxt_payload_i(pay_w[i+1]),
			.tok_o        (tok_w[i+1]),
			.rem_o        (rem_w[i+1]),
			.key_o        (key_w[i]),
			.payload_o    (pay_w[i])
		);
	end

	for (genvar j = 0; j <= CAPACITY; j++) begin : g_act
		assign act_vec[j] = tok_w[j].active;
	end

	assign tok_end  = tok_w[CAPACITY];
	assign tok_done = tok_end.active;

	// result decode when the token leaves the row
	always_comb begin
		end_count = count_q;
		case (tok_end.op)
			OP_INSERT: begin
				if (tok_end.hit) begin
					end_status = ST_DUPLICATE;
				end else begin
					end_status = ST_INSERTED;
					end_count  = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (tok_end.hit) begin
					end_status = ST_REMOVED;
					end_count  = count_q - CNT_W'(1);
				end else begin
					end_status = ST_NOT_FOUND;
				end
			end
			OP_FULL: begin
				end_status = ST_FULL;
			end
			default: begin
				end_status = ST_NOT_FOUND;
			end
		endcase
	end

	// control: walk the row, park the result, hand it to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (tok_done) begin
						count_q <= end_count;
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result data registers
	always_ff @(posedge clk) begin
		if (state_q == S_RUN && tok_done) begin
			pend_status_q <= end_status;
			pend_count_q  <= 8'(end_count);
		end
		if (state_q == S_HOLD && out_free) begin
			out_status_q <= pend_status_q;
			out_count_q  <= pend_count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;

	// at most one token walks the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_vec))
		else $error("more than one token in the cell row");

	// the count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("record count above capacity");

	// a token only leaves the row while a walk is in progress
	a_end_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok_done |-> state_q == S_RUN)
		else $error("token left the row outside a walk");

	// a fresh result comes only out of the hold state
	a_out_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_HOLD)
		else $error("result shown without a finished walk");

	// the count changes only when a token leaves the row, by at most one per operation
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(tok_done))
		else $error("record count changed without a finished walk");

endmodule
